### sv/sacfl_pkg.sv
// ---------------------------------------------------------------------------
// sacfl_pkg
// Shared constants and types for the set-associative cache lookup with FIFO
// replacement.
// ---------------------------------------------------------------------------
package sacfl_pkg;

   localparam int OFFSET_BITS  = 4;
   localparam int INDEX_BITS   = 6;
   localparam int WAYS         = 4;
   localparam int ADDRESS_BITS = 32;

   localparam int ADDR_W    = 32;
   localparam int WAY_OUT_W = 2;
   localparam int COUNT_W   = 32;

   localparam int TAG_BITS_RAW = ADDRESS_BITS - OFFSET_BITS - INDEX_BITS;
   localparam int TAG_BITS     = (TAG_BITS_RAW > 0) ? TAG_BITS_RAW : 0;
   localparam int TAG_W        = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int TAG_LSB      = OFFSET_BITS + INDEX_BITS;

   localparam int SET_COUNT = 1 << INDEX_BITS;
   localparam int SET_W     = (INDEX_BITS > 0) ? INDEX_BITS : 1;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);
   localparam logic [TAG_W-1:0] TAG_MASK =
      (TAG_BITS > 0) ? {TAG_W{1'b1}} : {TAG_W{1'b0}};
   localparam logic [SET_W-1:0] SET_MASK =
      (INDEX_BITS > 0) ? {SET_W{1'b1}} : {SET_W{1'b0}};
   localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef logic [TAG_W-1:0] tag_type;
   typedef logic [SET_W-1:0] set_type;
   typedef logic [WAY_W-1:0] way_type;
   typedef logic [COUNT_W-1:0] count_type;

   // one memory row: tags of all ways of a set plus the most recently filled way
   typedef struct packed {
      way_type                newest;
      logic [WAYS-1:0][TAG_W-1:0] tags;
   } row_type;

   typedef struct packed {
      logic    hit;
      way_type way;
   } pick_type;

   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == COUNT_MAX) ? v : v + count_type'(1);
   endfunction

endpackage

### sv/sacfl_if.sv
// ---------------------------------------------------------------------------
// sacfl_req_if / sacfl_rsp_if
// Valid/ready channels for lookup requests and lookup results.
// ---------------------------------------------------------------------------
interface sacfl_req_if;
   logic                          valid;
   logic                          ready;
   logic [sacfl_pkg::ADDR_W-1:0]  address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface sacfl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [sacfl_pkg::WAY_OUT_W-1:0] way;
   logic [sacfl_pkg::COUNT_W-1:0]   hit_count;
   logic [sacfl_pkg::COUNT_W-1:0]   miss_count;

   modport source (output valid, output hit, output way, output hit_count,
                   output miss_count, input ready);
   modport sink   (input valid, input hit, input way, input hit_count,
                   input miss_count, output ready);
endinterface

### sv/sacfl_tag_ram.sv
// ---------------------------------------------------------------------------
// sacfl_tag_ram
// One-port-write, one-port-read set memory with registered read data.
// ---------------------------------------------------------------------------
module sacfl_tag_ram (
   input  logic                clock,
   input  logic                wr_en,
   input  sacfl_pkg::set_type  wr_addr,
   input  sacfl_pkg::row_type  wr_data,
   input  logic                rd_en,
   input  sacfl_pkg::set_type  rd_addr,
   output sacfl_pkg::row_type  rd_data
);

   sacfl_pkg::row_type mem_ff [sacfl_pkg::SET_COUNT];
   sacfl_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sacfl_way_select.sv
// ---------------------------------------------------------------------------
// sacfl_way_select
// Tag compare across the ways of a set; picks the hit way, else the first
// empty way, else the way after the newest one.
// ---------------------------------------------------------------------------
module sacfl_way_select (
   input  sacfl_pkg::row_type          row,
   input  logic [sacfl_pkg::WAYS-1:0]  filled,
   input  sacfl_pkg::tag_type          tag,
   output sacfl_pkg::pick_type         pick
);

   logic               hit;
   logic               empty_found;
   sacfl_pkg::way_type hit_way;
   sacfl_pkg::way_type empty_way;
   sacfl_pkg::way_type victim_way;

   always_comb begin
      hit         = 1'b0;
      hit_way     = '0;
      empty_found = 1'b0;
      empty_way   = '0;
      for (int w = 0; w < sacfl_pkg::WAYS; w++) begin
         if (!hit && filled[w] && (row.tags[w] == tag)) begin
            hit     = 1'b1;
            hit_way = sacfl_pkg::way_type'(w);
         end
         if (!empty_found && !filled[w]) begin
            empty_found = 1'b1;
            empty_way   = sacfl_pkg::way_type'(w);
         end
      end
      victim_way = (row.newest == sacfl_pkg::LAST_WAY) ? '0
                   : row.newest + sacfl_pkg::way_type'(1);
      priority if (hit) begin
         pick = '{hit: 1'b1, way: hit_way};
      end else if (empty_found) begin
         pick = '{hit: 1'b0, way: empty_way};
      end else begin
         pick = '{hit: 1'b0, way: victim_way};
      end
   end

endmodule

### sv/set_assoc_cache_fifo_lookup.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_fifo_lookup
// Set-associative cache lookup with FIFO replacement and saturating
// hit/miss counters.
// ---------------------------------------------------------------------------
// One address beat in gives one result beat out. Sustained rate is one beat
// per cycle; the set row (all tags plus the newest-way pointer) is read from
// a synchronous memory at the accepting edge, then compared and, on a miss,
// updated and written back while the result register loads. A stalled
// result holds the lookup stage and the request side. A row written back in
// the same cycle that the next request to that set is accepted is forwarded
// from a holding register. Filled marks live in flops cleared by reset, so
// the block is ready directly after reset with no clearing pass.
// ---------------------------------------------------------------------------
module set_assoc_cache_fifo_lookup (
   input  logic                clock,
   input  logic                reset,
   sacfl_req_if.sink           req_chan,
   sacfl_rsp_if.source         rsp_chan
);

   logic                       lk_valid_ff;
   sacfl_pkg::set_type         lk_set_ff;
   sacfl_pkg::tag_type         lk_tag_ff;
   logic                       lk_fwd_ff;
   logic                       lk_fwd_in;
   sacfl_pkg::row_type         fwd_row_ff;

   logic [sacfl_pkg::SET_COUNT-1:0][sacfl_pkg::WAYS-1:0] filled_ff;

   sacfl_pkg::count_type       hits_ff;
   sacfl_pkg::count_type       hits_in;
   sacfl_pkg::count_type       misses_ff;
   sacfl_pkg::count_type       misses_in;

   logic                       rsp_valid_ff;
   logic                       rsp_hit_ff;
   logic [sacfl_pkg::WAY_OUT_W-1:0] rsp_way_ff;
   logic [sacfl_pkg::WAY_OUT_W-1:0] rsp_way_in;

   logic                       accept;
   logic                       advance;
   logic                       wr_en;
   logic [sacfl_pkg::ADDR_W-1:0] addr;
   sacfl_pkg::set_type         req_set;
   sacfl_pkg::tag_type         req_tag;
   sacfl_pkg::row_type         rd_row;
   sacfl_pkg::row_type         row;
   sacfl_pkg::row_type         wr_row;
   sacfl_pkg::pick_type        pick;
   logic [sacfl_pkg::WAY_W+sacfl_pkg::WAY_OUT_W-1:0] way_wide;

   assign addr    = req_chan.address & sacfl_pkg::ADDR_MASK;
   assign req_set = sacfl_pkg::set_type'(addr >> sacfl_pkg::OFFSET_BITS) & sacfl_pkg::SET_MASK;
   assign req_tag = sacfl_pkg::tag_type'(addr >> sacfl_pkg::TAG_LSB) & sacfl_pkg::TAG_MASK;

   assign advance        = lk_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !lk_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   sacfl_tag_ram u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lk_set_ff),
      .wr_data (wr_row),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (rd_row)
   );

   assign row = lk_fwd_ff ? fwd_row_ff : rd_row;

   sacfl_way_select u_way_select (
      .row    (row),
      .filled (filled_ff[lk_set_ff]),
      .tag    (lk_tag_ff),
      .pick   (pick)
   );

   always_comb begin
      wr_en  = advance && !pick.hit;
      wr_row = row;
      wr_row.tags[pick.way] = lk_tag_ff;
      wr_row.newest         = pick.way;
      lk_fwd_in = wr_en && (lk_set_ff == req_set);
      hits_in   = pick.hit ? sacfl_pkg::sat_inc(hits_ff) : hits_ff;
      misses_in = pick.hit ? misses_ff : sacfl_pkg::sat_inc(misses_ff);
      way_wide  = {{sacfl_pkg::WAY_OUT_W{1'b0}}, pick.way};
      rsp_way_in = way_wide[sacfl_pkg::WAY_OUT_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         filled_ff    <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         if (req_chan.ready) begin
            lk_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            hits_ff      <= hits_in;
            misses_ff    <= misses_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            filled_ff[lk_set_ff][pick.way] <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         lk_set_ff <= req_set;
         lk_tag_ff <= req_tag;
         lk_fwd_ff <= lk_fwd_in;
      end
      if (wr_en) begin
         fwd_row_ff <= wr_row;
      end
      if (advance) begin
         rsp_hit_ff <= pick.hit;
         rsp_way_ff <= rsp_way_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.way        = rsp_way_ff;
   assign rsp_chan.hit_count  = hits_ff;
   assign rsp_chan.miss_count = misses_ff;

endmodule
